// File: rtl/mlfq_pkg.sv
package mlfq_pkg;

    typedef enum logic [2:0] {
        EV_RAN      = 3'd0,
        EV_FINISHED = 3'd1,
        EV_DEMOTED  = 3'd2,
        EV_IDLE     = 3'd3,
        EV_ACCEPTED = 3'd4,
        EV_REJECTED = 3'd5
    } t_event;

    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [1:0] REG_LEVEL_COUNT = 2'd0;
    localparam logic [1:0] REG_SLICES      = 2'd1;
    localparam logic [1:0] REG_BOOST       = 2'd2;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ARRIVE,     // check arrival and register it
        CMD_BOOST_CLR,  // clear rings and start walk
        CMD_BOOST_STEP, // push one arrival-order entry
        CMD_FIND,       // pick highest level, issue ring read
        CMD_RUN,        // service head task
        CMD_RESULT      // load output register
    } t_cmd;

    typedef struct packed {
        logic boost_due;
        logic boost_last;
    } t_status;

endpackage

// File: rtl/mlfq_ram.sv
module mlfq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/mlfq_ctrl.sv
module mlfq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_op,
    input  mlfq_pkg::t_status  i_status,
    input  logic               i_out_busy,
    output logic               o_idle,
    output mlfq_pkg::t_cmd     o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_BCLR, S_BSTEP, S_FIND, S_WAIT, S_RUN, S_OUT
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_op == mlfq_pkg::OP_ARRIVAL) r_state <= S_OUT;
                        else if (i_status.boost_due) r_state <= S_BCLR;
                        else r_state <= S_FIND;
                    end
                end
                S_BCLR: r_state <= i_status.boost_last ? S_FIND : S_BSTEP;
                S_BSTEP: begin
                    if (i_status.boost_last) r_state <= S_FIND;
                end
                S_FIND: r_state <= S_WAIT;
                S_WAIT: r_state <= S_RUN;
                S_RUN: r_state <= S_OUT;
                S_OUT: begin
                    if (!i_out_busy) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd = mlfq_pkg::CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_op == mlfq_pkg::OP_ARRIVAL) o_cmd = mlfq_pkg::CMD_ARRIVE;
            end
            S_BCLR:  o_cmd = mlfq_pkg::CMD_BOOST_CLR;
            S_BSTEP: o_cmd = mlfq_pkg::CMD_BOOST_STEP;
            S_FIND:  o_cmd = mlfq_pkg::CMD_FIND;
            S_WAIT:  o_cmd = mlfq_pkg::CMD_NONE;
            S_RUN:   o_cmd = mlfq_pkg::CMD_RUN;
            S_OUT:   o_cmd = i_out_busy ? mlfq_pkg::CMD_NONE : mlfq_pkg::CMD_RESULT;
            default: o_cmd = mlfq_pkg::CMD_NONE;
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

    a_arrive_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start && i_op == mlfq_pkg::OP_ARRIVAL) |=> r_state == S_OUT)
        else $error("arrival did not go to result");
    a_run_after_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WAIT |=> r_state == S_RUN)
        else $error("run sequence broken");
    a_find_after_boost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BSTEP && i_status.boost_last) |=> r_state == S_FIND)
        else $error("boost walk did not end in find");
endmodule

// File: rtl/mlfq_dp.sv
module mlfq_dp #(
    parameter int TASKS  = 16,
    parameter int LEVELS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mlfq_pkg::t_cmd    i_cmd,
    input  logic [3:0]        i_task_id,
    input  logic [15:0]       i_need_time,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    output mlfq_pkg::t_status o_status,
    output logic [58:0]       o_result
);
    localparam int TW  = $clog2(TASKS);
    localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CW  = TW + 1;
    localparam int RAW = LW + TW;

    logic [3:0]  r_level_count;
    logic [63:0] r_slices;
    logic [15:0] r_boost_period;

    logic [TW-1:0] r_head [LEVELS];
    logic [CW-1:0] r_occ  [LEVELS];
    logic [15:0]   r_elapsed [TASKS];
    logic [15:0]   r_need [TASKS];
    logic          r_arrived [TASKS];
    logic          r_done [TASKS];
    logic [TW-1:0] r_order [TASKS];
    logic [CW-1:0] r_arr_total;
    logic [31:0]   r_time;
    logic [7:0]    r_slice_used;
    logic          r_last_valid;
    logic [TW-1:0] r_last_task;
    logic [15:0]   r_countdown;
    logic [CW-1:0] r_walk;
    logic          r_boosted;
    logic          r_found;
    logic [LW-1:0] r_lvl;
    logic [25:0]   r_result;

    logic [LW-1:0] w_top;
    logic [3:0]    w_lc;
    logic          w_id_ok;
    logic [TW-1:0] w_id;
    logic          w_we;
    logic [RAW-1:0] w_waddr, w_raddr;
    logic [TW-1:0] w_wdata, w_rdata;
    logic [TW-1:0] w_cur;
    logic [15:0]   w_el_next;
    logic [7:0]    w_su, w_slice;
    logic          w_fnd;
    logic [LW-1:0] w_fl;
    logic [LW-1:0] w_dn;
    logic [TW-1:0] w_wt;
    logic          w_finish;
    logic          w_demote;

    // ring index modulo TASKS; sum is always below 2 * TASKS
    function automatic logic [TW-1:0] f_wrap(input logic [CW-1:0] sum);
        return (sum >= CW'(TASKS)) ? TW'(sum - CW'(TASKS)) : TW'(sum);
    endfunction

    always_comb begin
        w_lc = (r_level_count == 4'd0) ? 4'd1 : r_level_count;
        if (32'(w_lc) > LEVELS) w_lc = 4'(LEVELS);
        w_top = LW'(w_lc - 4'd1);
    end

    assign w_id_ok = ({28'd0, i_task_id} < TASKS);
    assign w_id    = TW'(i_task_id);
    assign w_wt    = r_order[r_walk[TW-1:0]];

    always_comb begin
        w_fnd = 1'b0;
        w_fl  = '0;
        for (int l = 0; l < LEVELS; l++) begin
            if (l < 32'(w_lc) && r_occ[l] != '0) begin
                w_fnd = 1'b1;
                w_fl  = LW'(l);
            end
        end
    end

    assign w_cur   = w_rdata;
    assign w_su    = (!r_last_valid || r_last_task != w_cur) ? 8'd1 :
                     ((r_slice_used == 8'd255) ? 8'd255 : r_slice_used + 8'd1);
    assign w_el_next = (r_elapsed[w_cur] == 16'hFFFF) ? 16'hFFFF : r_elapsed[w_cur] + 16'd1;
    assign w_slice = (r_slices[8*r_lvl +: 8] == 8'd0) ? 8'd1 : r_slices[8*r_lvl +: 8];
    assign w_dn    = (r_lvl == '0) ? '0 : r_lvl - LW'(1);
    assign w_finish = (w_el_next >= r_need[w_cur]);
    assign w_demote = !w_finish && (w_su >= w_slice);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = {w_top, r_occ[w_top][TW-1:0]};
        w_wdata = w_id;
        unique case (i_cmd)
            mlfq_pkg::CMD_ARRIVE: begin
                w_we = w_id_ok && !r_arrived[w_id] && r_occ[w_top] < CW'(TASKS);
                w_waddr = {w_top, f_wrap({1'b0, r_head[w_top]} + r_occ[w_top])};
            end
            mlfq_pkg::CMD_BOOST_STEP: begin
                w_we = !r_done[w_wt] && r_occ[w_top] < CW'(TASKS);
                w_waddr = {w_top, r_occ[w_top][TW-1:0]};
                w_wdata = w_wt;
            end
            mlfq_pkg::CMD_RUN: begin
                // same-level demotion pops and pushes: tail slot stays valid
                w_we = r_found && w_demote
                       && (w_dn == r_lvl || r_occ[w_dn] < CW'(TASKS));
                w_waddr = {w_dn, f_wrap({1'b0, r_head[w_dn]} + r_occ[w_dn])};
                w_wdata = w_cur;
            end
            default: ;
        endcase
    end

    assign w_raddr = {w_fl, r_head[w_fl]};

    mlfq_ram #(.WIDTH(TW), .DEPTH(1 << RAW)) u_rings (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_count  <= 4'd3;
            r_slices       <= 64'd132104;
            r_boost_period <= 16'd100;
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i] <= '0;
                r_occ[i]  <= '0;
            end
            for (int i = 0; i < TASKS; i++) begin
                r_elapsed[i] <= '0;
                r_arrived[i] <= 1'b0;
                r_done[i]    <= 1'b0;
            end
            r_arr_total  <= '0;
            r_time       <= '0;
            r_slice_used <= '0;
            r_last_valid <= 1'b0;
            r_last_task  <= '0;
            r_countdown  <= '0;
            r_walk       <= '0;
            r_boosted    <= 1'b0;
            r_found      <= 1'b0;
            r_lvl        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mlfq_pkg::REG_LEVEL_COUNT: r_level_count <= i_cfg_data[3:0];
                    mlfq_pkg::REG_SLICES:      r_slices <= i_cfg_data;
                    mlfq_pkg::REG_BOOST:       r_boost_period <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            unique case (i_cmd)
                mlfq_pkg::CMD_ARRIVE: begin
                    r_boosted <= 1'b0;
                    r_result[6:3] <= i_task_id;
                    if (w_id_ok && !r_arrived[w_id]) begin
                        r_arrived[w_id] <= 1'b1;
                        r_done[w_id]    <= 1'b0;
                        r_elapsed[w_id] <= '0;
                        r_need[w_id]    <= i_need_time;
                        if (r_arr_total < CW'(TASKS)) begin
                            r_order[r_arr_total[TW-1:0]] <= w_id;
                            r_arr_total <= r_arr_total + CW'(1);
                        end
                        if (r_occ[w_top] < CW'(TASKS)) r_occ[w_top] <= r_occ[w_top] + CW'(1);
                        r_result[2:0]   <= mlfq_pkg::EV_ACCEPTED;
                        r_result[9:7]   <= 3'(w_top);
                        r_result[25:10] <= '0;
                    end else begin
                        r_result[2:0]   <= mlfq_pkg::EV_REJECTED;
                        r_result[9:7]   <= '0;
                        r_result[25:10] <= (w_id_ok) ? r_elapsed[w_id] : 16'd0;
                    end
                end
                mlfq_pkg::CMD_BOOST_CLR: begin
                    for (int i = 0; i < LEVELS; i++) begin
                        r_head[i] <= '0;
                        r_occ[i]  <= '0;
                    end
                    r_walk       <= '0;
                    r_boosted    <= 1'b1;
                    r_slice_used <= '0;
                    r_countdown  <= (r_boost_period == 16'd0) ? 16'd1 : r_boost_period;
                end
                mlfq_pkg::CMD_BOOST_STEP: begin
                    r_walk <= r_walk + CW'(1);
                    if (w_we) r_occ[w_top] <= r_occ[w_top] + CW'(1);
                end
                mlfq_pkg::CMD_FIND: begin
                    r_found     <= w_fnd;
                    r_lvl       <= w_fl;
                    r_countdown <= r_countdown - 16'd1;
                    r_time      <= r_time + 32'd1;
                end
                mlfq_pkg::CMD_RUN: begin
                    if (r_found) begin
                        r_last_valid <= 1'b1;
                        r_last_task  <= w_cur;
                        r_elapsed[w_cur] <= w_el_next;
                        r_result[6:3]   <= 4'(w_cur);
                        r_result[9:7]   <= 3'(r_lvl);
                        r_result[25:10] <= w_el_next;
                        if (w_finish) begin
                            r_slice_used  <= w_su;
                            r_done[w_cur] <= 1'b1;
                            r_head[r_lvl] <= f_wrap({1'b0, r_head[r_lvl]} + CW'(1));
                            r_occ[r_lvl]  <= r_occ[r_lvl] - CW'(1);
                            r_result[2:0] <= mlfq_pkg::EV_FINISHED;
                        end else if (w_demote) begin
                            r_slice_used  <= '0;
                            r_head[r_lvl] <= f_wrap({1'b0, r_head[r_lvl]} + CW'(1));
                            r_result[2:0] <= mlfq_pkg::EV_DEMOTED;
                            if (w_dn != r_lvl) begin
                                r_occ[r_lvl] <= r_occ[r_lvl] - CW'(1);
                                if (r_occ[w_dn] < CW'(TASKS))
                                    r_occ[w_dn] <= r_occ[w_dn] + CW'(1);
                            end
                        end else begin
                            r_slice_used  <= w_su;
                            r_result[2:0] <= mlfq_pkg::EV_RAN;
                        end
                    end else begin
                        r_result[2:0]   <= mlfq_pkg::EV_IDLE;
                        r_result[6:3]   <= '0;
                        r_result[9:7]   <= '0;
                        r_result[25:10] <= '0;
                    end
                end
                mlfq_pkg::CMD_RESULT: begin
                    r_boosted <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_status.boost_due  = (r_countdown == 16'd0);
    assign o_status.boost_last = (i_cmd == mlfq_pkg::CMD_BOOST_CLR) ? (r_arr_total == '0)
                                 : (r_walk + CW'(1) >= r_arr_total);
    assign o_result = {r_boosted, r_time, r_result};

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ[w_top] <= CW'(TASKS))
        else $error("occupancy over capacity");
    a_time_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == mlfq_pkg::CMD_FIND |=> r_time == $past(r_time) + 32'd1)
        else $error("time did not advance");
    a_boost_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == mlfq_pkg::CMD_BOOST_CLR |=> r_countdown != 16'd0)
        else $error("countdown not reloaded");
endmodule

// File: rtl/multilevel_feedback_queue_scheduler.sv
// Sequence: an arrival is checked and registered, then its result is loaded; a tick
//   passes FIND, WAIT, RUN and OUT, after BCLR and a BSTEP per arrived task on a boost.
// Throughput: one request at a time; the next request is accepted once the previous
//   result has been loaded into the output register.
// The boost walk over the arrival list and the ring memory read port shape the tick sequence.
// Reset (i_rst_n low, synchronous): queues empty, no tasks, time 0, boost on first tick.
module multilevel_feedback_queue_scheduler #(
    parameter int TASKS  = 16,
    parameter int LEVELS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // task_id[3:0], need_time[19:4], zero pad
    input  logic        s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // event_res, served_task, served_level,
                                        // served_elapsed, current_time, boosted, pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    mlfq_pkg::t_cmd    w_cmd;
    mlfq_pkg::t_status w_status;
    logic              w_idle;
    logic [58:0]       w_result;
    logic              r_out_valid;
    logic [58:0]       r_out_data;

    assign s_axis_tready = w_idle;
    assign o_cfg_ready   = 1'b1;

    mlfq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (s_axis_tvalid),
        .i_op      (s_axis_tuser),
        .i_status  (w_status),
        .i_out_busy(r_out_valid && !m_axis_tready),
        .o_idle    (w_idle),
        .o_cmd     (w_cmd)
    );

    mlfq_dp #(.TASKS(TASKS), .LEVELS(LEVELS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_task_id  (s_axis_tdata[3:0]),
        .i_need_time(s_axis_tdata[19:4]),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_status   (w_status),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd == mlfq_pkg::CMD_RESULT) begin
            r_out_valid <= 1'b1;
            r_out_data  <= w_result;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_data};
endmodule
